/* design/ptb_pkg.sv */
// Package for the periodic timer bank: sizes, command codes, word types and
// the structs that pass between the top level and the timer cells. No dependencies.
`default_nettype none

package ptb_pkg;

   localparam int NUM_TIMERS = 8;
   localparam int TIME_BITS  = 32;

   localparam logic [15:0] MAX_WAKEUP_RESET = 16'd30;

   // Wide enough to compare any timer number against the 3-bit index field.
   localparam int SEL_W = 7;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [NUM_TIMERS-1:0] mask_type;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_STOP    = 2'd1,
      CMD_PROCESS = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  timer_index;
      logic [30:0] interval;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [7:0]  fired_mask;
      logic [15:0] wakeup;
      logic        status;
   } rsp_type;

   // Write strobe broadcast to every cell; each cell also gets its own select.
   typedef struct packed {
      logic     start;
      logic     stop;
      time_type now;
      time_type interval;
   } cell_wr_type;

   // Sweep token handed from cell to cell during a process word.
   typedef struct packed {
      logic        valid;
      time_type    now;
      logic [15:0] wake;
      mask_type    fired;
   } token_type;

endpackage : ptb_pkg

`default_nettype wire

/* design/ptb_cell.sv */
// One timer cell: holds the active flag, deadline and period of a single timer
// and processes the sweep token as it passes. Depends on ptb_pkg.
`default_nettype none

module ptb_cell
   import ptb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        sel,
   input  wire cell_wr_type wr,
   input  wire token_type   tok_in,
   output      token_type   tok_out
);

   logic      active_ff, active_in;
   time_type  deadline_ff, deadline_in;
   time_type  period_ff, period_in;
   token_type tok_ff, tok_in_next;

   time_type diff;
   time_type remain;
   logic     expired;
   mask_type fired_bit;

   always_comb begin
      diff      = deadline_ff - tok_in.now;
      expired   = active_ff && ((diff == '0) || diff[TIME_BITS-1]);
      remain    = expired ? period_ff : diff;
      fired_bit = mask_type'(expired) << (NUM_TIMERS - 1);

      active_in   = active_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;

      if (sel && wr.start) begin
         active_in   = 1'b1;
         period_in   = wr.interval;
         deadline_in = wr.now + wr.interval;
      end else if (sel && wr.stop) begin
         active_in = 1'b0;
      end else if (tok_in.valid && expired) begin
         deadline_in = tok_in.now + period_ff;
      end

      tok_in_next       = tok_in;
      tok_in_next.fired = (tok_in.fired >> 1) | fired_bit;
      if (active_ff && (64'(remain) < 64'(tok_in.wake))) begin
         tok_in_next.wake = 16'(remain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         active_ff    <= active_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      deadline_ff  <= deadline_in;
      period_ff    <= period_in;
      tok_ff.now   <= tok_in_next.now;
      tok_ff.wake  <= tok_in_next.wake;
      tok_ff.fired <= tok_in_next.fired;
   end

   assign tok_out = tok_ff;

endmodule : ptb_cell

`default_nettype wire

/* design/periodic_timer_bank.sv */
// Periodic timer bank: top level with the request/response handshake, the
// configuration register and the chain of timer cells. Depends on ptb_pkg, ptb_cell.
// Timing: start, stop and unused words answer in the cycle after acceptance;
// a process word answers once the sweep token has passed every cell and the result is registered,
// the token stepping through one cell per cycle.
// Throughput: one word at a time; with the response taken at once, a start, stop or
// unused word every cycle, while after a process word no new word is taken until it has answered.
// Reset (synchronous, active high): all timers inactive, max_wakeup 30, no response.
`default_nettype none

module periodic_timer_bank
   import ptb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   state_type   state_ff, state_in;
   logic [15:0] max_wakeup_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        sweep_done;
   cell_wr_type wr;
   token_type   inject;
   token_type   chain [0:NUM_TIMERS];
   logic [NUM_TIMERS-1:0] sel;
   logic [NUM_TIMERS+7:0] fired_wide;

   // A word is taken only when no sweep is running and the response slot is
   // empty or is being emptied in this same cycle.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Start and stop go straight to the addressed cell at acceptance. A start
   // with a zero interval writes nothing. Indexes past the bank select no cell.
   assign wr.start    = accept && (req_data.cmd == CMD_START) && (req_data.interval != '0);
   assign wr.stop     = accept && (req_data.cmd == CMD_STOP);
   assign wr.now      = time_type'(req_data.now);
   assign wr.interval = time_type'(req_data.interval);

   // A process word launches a token into the first cell. It carries the
   // running minimum, seeded with the configured limit, and a fired mask into
   // which each cell shifts its own bit so that timer 0 lands in bit 0.
   assign inject.valid = accept && (req_data.cmd == CMD_PROCESS);
   assign inject.now   = time_type'(req_data.now);
   assign inject.wake  = max_wakeup_ff;
   assign inject.fired = '0;

   assign chain[0] = inject;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      assign sel[i] = (SEL_W'(req_data.timer_index) == SEL_W'(i));

      ptb_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .sel     (sel[i]),
         .wr      (wr),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   assign sweep_done = chain[NUM_TIMERS].valid;
   assign fired_wide = {8'd0, chain[NUM_TIMERS].fired};

   // The sweep state only tracks whether a token is still in the chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               if (req_data.cmd == CMD_PROCESS) begin
                  state_in = ST_SWEEP;
               end else begin
                  // Start, stop and the unused code answer right away.
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = (req_data.cmd == CMD_START) &&
                                       (req_data.interval == '0);
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in               = ST_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_data_in.fired_mask = fired_wide[7:0];
               rsp_data_in.wakeup     = chain[NUM_TIMERS].wake;
               rsp_data_in.status     = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         max_wakeup_ff <= MAX_WAKEUP_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_wakeup_ff <= csr_wdata;
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : periodic_timer_bank

`default_nettype wire
